>>> hdl/ugb_pkg.sv
// ---------------------------------------------------------------------------
// Uniform grid binning package
// Shared widths, codes and state encoding for the grid binning block.
// ---------------------------------------------------------------------------
`default_nettype none

package ugb_pkg;

  // Default sizes of the storage.
  localparam int MAX_CELLS_DEF      = 1024;
  localparam int ITEM_CAPACITY_DEF  = 2048;
  localparam int MAX_CANDIDATES_DEF = 64;

  // Field widths.
  localparam int ACT_W    = 3;
  localparam int ID_W     = 16;
  localparam int POS_W    = 16;
  localparam int SIZE_W   = 15;
  localparam int COL_W    = 11;
  localparam int CSZ_W    = 15;
  localparam int TOUCH_W  = 3;
  localparam int STAT_W   = 2;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // Corner coordinate (position plus extent) and its magnitude.
  localparam int COORD_W  = 18;
  localparam int MAG_W    = 17;
  // Row offset y * num_columns and the signed cell index.
  localparam int PROD_W   = 28;
  localparam int IDX_W    = 30;
  // Divider iteration counter.
  localparam int DCNT_W   = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 3'd0,
    ACT_COUNT  = 3'd1,
    ACT_PREFIX = 3'd2,
    ACT_PLACE  = 3'd3,
    ACT_QUERY  = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_NUM_COLUMNS = 2'd0,
    REG_NUM_ROWS    = 2'd1,
    REG_CELL_SIZE   = 2'd2,
    REG_FIRST_ID    = 2'd3
  } reg_addr_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_PFX_RD,
    S_PFX_WR,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL1,
    S_IDX1,
    S_MUL2,
    S_IDX2,
    S_SEL,
    S_DISPATCH,
    S_CELL_RD,
    S_CELL_WR,
    S_Q_CELL_RD,
    S_Q_CELL_DAT,
    S_Q_ITEM,
    S_Q_ITEM_WR,
    S_Q_DONE,
    S_EMIT_RD,
    S_EMIT_LD,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

>>> hdl/ugb_ram.sv
// ---------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module ugb_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/ugb_fdiv.sv
// ---------------------------------------------------------------------------
// Serial floor divider
// Signed dividend over a positive divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ugb_fdiv (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [ugb_pkg::COORD_W-1:0] dividend,
  input  wire logic        [ugb_pkg::CSZ_W-1:0]   divisor,
  output logic                                   done,
  output logic signed      [ugb_pkg::COORD_W-1:0] quotient
);

  logic                          busy;
  logic [ugb_pkg::DCNT_W-1:0]    cnt;
  logic                          neg;
  logic [ugb_pkg::MAG_W-1:0]     mag;
  logic [ugb_pkg::CSZ_W-1:0]     rem;
  logic [ugb_pkg::CSZ_W-1:0]     dsr;
  logic [ugb_pkg::CSZ_W:0]       trial;
  logic                          qbit;
  logic [ugb_pkg::MAG_W-1:0]     mag_next;
  logic [ugb_pkg::CSZ_W-1:0]     rem_next;
  logic signed [ugb_pkg::COORD_W-1:0] neg_q;

  always_comb begin
    trial    = {rem, mag[ugb_pkg::MAG_W-1]};
    qbit     = (trial >= {1'b0, dsr});
    rem_next = qbit ? ugb_pkg::CSZ_W'(trial - {1'b0, dsr}) : ugb_pkg::CSZ_W'(trial);
    mag_next = {mag[ugb_pkg::MAG_W-2:0], qbit};
    // Rounding toward minus infinity for a negative dividend.
    neg_q    = -$signed(ugb_pkg::COORD_W'(mag_next))
               - $signed(ugb_pkg::COORD_W'(rem_next != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= dividend[ugb_pkg::COORD_W-1];
        mag  <= dividend[ugb_pkg::COORD_W-1] ?
                ugb_pkg::MAG_W'(-dividend) : ugb_pkg::MAG_W'(dividend);
        rem  <= '0;
        dsr  <= (divisor == '0) ? ugb_pkg::CSZ_W'(1) : divisor;
      end else if (busy) begin
        mag <= mag_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == ugb_pkg::DCNT_W'(ugb_pkg::MAG_W - 1)) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= neg ? neg_q : $signed(ugb_pkg::COORD_W'(mag_next));
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/uniform_grid_binning_unit.sv
// ---------------------------------------------------------------------------
// Uniform grid binning unit
// Broad-phase grid built by counting sort: clear, count, prefix, place and
// query boxes against a grid of cells kept in on-chip memory.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_ready   action, element_id, pos, size
//  result    out        result_valid/result_ready candidate_id .. status
//  config    in         APB psel/penable/pready   num_columns .. first_id
//
// A count, place or query request runs four corner divisions in turn on the
// shared serial floor divider, then the cell index states (multiply, index,
// multiply, index, select, dispatch); count and place then read and write
// each touched cell on the cell memory, while a query reads each touched
// cell, collects its candidates and hands each result out. Prefix reads and
// writes back every cell entry in turn, clear writes every entry once.
// After reset a clearing pass zeroes every entry of the cell memory;
// no request is taken during it, configuration writes are.
// The result register holds a finished result while the next request is
// taken; the block stalls only where it must load a new result.
// ---------------------------------------------------------------------------
`default_nettype none

module uniform_grid_binning_unit #(
  parameter int MAX_CELLS      = ugb_pkg::MAX_CELLS_DEF,
  parameter int ITEM_CAPACITY  = ugb_pkg::ITEM_CAPACITY_DEF,
  parameter int MAX_CANDIDATES = ugb_pkg::MAX_CANDIDATES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Request channel.
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire logic [ugb_pkg::ACT_W-1:0]         action,
  input  wire logic [ugb_pkg::ID_W-1:0]          element_id,
  input  wire logic signed [ugb_pkg::POS_W-1:0]  pos_x,
  input  wire logic signed [ugb_pkg::POS_W-1:0]  pos_y,
  input  wire logic [ugb_pkg::SIZE_W-1:0]        size_x,
  input  wire logic [ugb_pkg::SIZE_W-1:0]        size_y,
  // Result channel.
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output logic [ugb_pkg::ID_W-1:0]               candidate_id,
  output logic                                   valid_res,
  output logic                                   last,
  output logic [ugb_pkg::TOUCH_W-1:0]            cells_touched,
  output logic [ugb_pkg::STAT_W-1:0]             status,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ugb_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [ugb_pkg::PDATA_W-1:0]       pwdata,
  output logic [ugb_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready
);

  localparam int CAW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int NCW = $clog2(MAX_CELLS + 1);
  localparam int CW  = $clog2(ITEM_CAPACITY + 1);
  localparam int IAW = $clog2(ITEM_CAPACITY);
  localparam int KAW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int KW  = $clog2(MAX_CANDIDATES + 1);
  localparam int NCP_W = 2 * ugb_pkg::COL_W;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [ugb_pkg::COL_W-1:0] num_columns;
  logic [ugb_pkg::COL_W-1:0] num_rows;
  logic [ugb_pkg::CSZ_W-1:0] cell_size;
  logic [ugb_pkg::ID_W-1:0]  first_id;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_columns <= ugb_pkg::COL_W'(32);
      num_rows    <= ugb_pkg::COL_W'(32);
      cell_size   <= ugb_pkg::CSZ_W'(512);
      first_id    <= ugb_pkg::ID_W'(4);
    end else if (cfg_wr) begin
      unique case (ugb_pkg::reg_addr_t'(paddr[3:2]))
        ugb_pkg::REG_NUM_COLUMNS: num_columns <= pwdata[ugb_pkg::COL_W-1:0];
        ugb_pkg::REG_NUM_ROWS:    num_rows    <= pwdata[ugb_pkg::COL_W-1:0];
        ugb_pkg::REG_CELL_SIZE:   cell_size   <= pwdata[ugb_pkg::CSZ_W-1:0];
        ugb_pkg::REG_FIRST_ID:    first_id    <= pwdata[ugb_pkg::ID_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (ugb_pkg::reg_addr_t'(paddr[3:2]))
      ugb_pkg::REG_NUM_COLUMNS: prdata = ugb_pkg::PDATA_W'(num_columns);
      ugb_pkg::REG_NUM_ROWS:    prdata = ugb_pkg::PDATA_W'(num_rows);
      ugb_pkg::REG_CELL_SIZE:   prdata = ugb_pkg::PDATA_W'(cell_size);
      ugb_pkg::REG_FIRST_ID:    prdata = ugb_pkg::PDATA_W'(first_id);
    endcase
  end

  // Cells in use, columns times rows capped at the memory depth, refreshed every
  // cycle. The user changes configuration only while idle; nothing enforces it.
  logic [NCP_W-1:0] nc_prod;
  logic [NCW-1:0]   nc_reg;

  assign nc_prod = NCP_W'(num_columns) * NCP_W'(num_rows);

  always_ff @(posedge clk) begin
    nc_reg <= (nc_prod > NCP_W'(MAX_CELLS)) ? NCW'(MAX_CELLS) : NCW'(nc_prod);
  end

  // -------------------------------------------------------------------------
  // Request registers and datapath state
  // -------------------------------------------------------------------------
  ugb_pkg::state_t state, state_next;

  ugb_pkg::action_t                  act;
  logic [ugb_pkg::ID_W-1:0]          id_r;
  logic signed [ugb_pkg::POS_W-1:0]  px_r, py_r;
  logic [ugb_pkg::SIZE_W-1:0]        sx_r, sy_r;

  logic [1:0]                        div_sel;
  logic signed [ugb_pkg::COORD_W-1:0] qv [4];
  logic [ugb_pkg::PROD_W-1:0]        prod;
  logic signed [ugb_pkg::IDX_W-1:0]  tl, tr, bl, br;
  logic [CAW-1:0]                    list [4];
  logic [2:0]                        n;
  logic [2:0]                        li;
  logic [ugb_pkg::TOUCH_W-1:0]       touched_r;
  ugb_pkg::status_t                  status_r;
  logic [CW-1:0]                     total;
  logic [CAW-1:0]                    sw;
  logic [CW-1:0]                     acc;
  logic [CW-1:0]                     q_head, q_count, j;
  logic [KW-1:0]                     k, ei;
  logic                              trunc;
  logic                              in_rng;

  // -------------------------------------------------------------------------
  // Shared floor divider: corners x1, y1, x2, y2 in that order
  // -------------------------------------------------------------------------
  logic                               div_start, div_done;
  logic signed [ugb_pkg::COORD_W-1:0] div_a, div_q;

  always_comb begin
    unique case (div_sel)
      2'd0: div_a = ugb_pkg::COORD_W'(px_r);
      2'd1: div_a = ugb_pkg::COORD_W'(py_r);
      2'd2: div_a = ugb_pkg::COORD_W'(px_r) + $signed(ugb_pkg::COORD_W'(sx_r));
      2'd3: div_a = ugb_pkg::COORD_W'(py_r) + $signed(ugb_pkg::COORD_W'(sy_r));
    endcase
  end

  ugb_fdiv u_fdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (cell_size),
    .done     (div_done),
    .quotient (div_q)
  );

  // -------------------------------------------------------------------------
  // Memories: cell table {count, head, fill}, item store, candidate buffer
  // -------------------------------------------------------------------------
  logic              cm_we;
  logic [CAW-1:0]    cm_waddr, cm_raddr;
  logic [3*CW-1:0]   cm_wdata, cm_rdata;
  logic              im_we;
  logic [IAW-1:0]    im_waddr, im_raddr;
  logic [ugb_pkg::ID_W-1:0] im_rdata;
  logic              kb_we;
  logic [KAW-1:0]    kb_waddr, kb_raddr;
  logic [ugb_pkg::ID_W-1:0] kb_wdata, kb_rdata;

  ugb_ram #(.DEPTH(MAX_CELLS), .AW(CAW), .DW(3 * CW)) u_cell_mem (
    .clk (clk), .we (cm_we), .waddr (cm_waddr), .wdata (cm_wdata),
    .raddr (cm_raddr), .rdata (cm_rdata)
  );

  ugb_ram #(.DEPTH(ITEM_CAPACITY), .AW(IAW), .DW(ugb_pkg::ID_W)) u_item_mem (
    .clk (clk), .we (im_we), .waddr (im_waddr), .wdata (id_r),
    .raddr (im_raddr), .rdata (im_rdata)
  );

  ugb_ram #(.DEPTH(MAX_CANDIDATES), .AW(KAW), .DW(ugb_pkg::ID_W)) u_cand_buf (
    .clk (clk), .we (kb_we), .waddr (kb_waddr), .wdata (kb_wdata),
    .raddr (kb_raddr), .rdata (kb_rdata)
  );

  logic [CW-1:0] c_cnt, c_head, c_fill;
  assign c_cnt  = cm_rdata[3*CW-1:2*CW];
  assign c_head = cm_rdata[2*CW-1:CW];
  assign c_fill = cm_rdata[CW-1:0];

  // -------------------------------------------------------------------------
  // Derived conditions
  // -------------------------------------------------------------------------
  logic          sw_last, sw_in_use;
  logic [CW:0]   place_addr, q_addr;
  logic          place_ok, over, li_last, cell_end, k_full, out_free;

  assign sw_last    = (sw == CAW'(MAX_CELLS - 1));
  assign sw_in_use  = (NCW'(sw) < nc_reg);
  assign place_addr = (CW + 1)'(c_head) + (CW + 1)'(c_fill);
  assign place_ok   = (place_addr < (CW + 1)'(ITEM_CAPACITY));
  assign q_addr     = (CW + 1)'(q_head) + (CW + 1)'(j);
  assign over       = ((CW + 1)'(total) + (CW + 1)'(n)) > (CW + 1)'(ITEM_CAPACITY);
  assign li_last    = ((li + 3'd1) == n);
  assign cell_end   = (j == q_count);
  assign k_full     = (k == KW'(MAX_CANDIDATES));
  assign out_free   = !result_valid || result_ready;

  // Keep rules and de-duplication of the four corner cells. The top row of
  // corners exists only when y1 is not negative, the bottom row when y2 is
  // not; a kept cell must also have a non-negative column and lie below the
  // cell count. Columns are not bounded, so an index may wrap into the next
  // row.
  logic signed [ugb_pkg::IDX_W-1:0] ncs;
  logic        ty1, ty2, x1ok, x2ok;
  logic        k_tl, k_tr, k_bl, k_br;
  logic [CAW-1:0] list_c [4];
  logic [2:0]  n_c;

  always_comb begin
    ncs  = $signed(ugb_pkg::IDX_W'(nc_reg));
    ty1  = !qv[1][ugb_pkg::COORD_W-1];
    ty2  = !qv[3][ugb_pkg::COORD_W-1];
    x1ok = !qv[0][ugb_pkg::COORD_W-1];
    x2ok = !qv[2][ugb_pkg::COORD_W-1];
    k_tl = ty1 && x1ok && (tl < ncs);
    k_tr = ty1 && x2ok && (tr < ncs) && (tr != tl);
    k_bl = ty2 && x1ok && (bl < ncs) && !(ty1 && (bl == tl)) && !(ty1 && (bl == tr));
    k_br = ty2 && x2ok && (br < ncs) && !(ty1 && (br == tl)) && !(ty1 && (br == tr))
           && (br != bl);
    list_c = list;
    n_c    = 3'd0;
    if (k_tl) begin
      list_c[n_c[1:0]] = tl[CAW-1:0];
      n_c = n_c + 3'd1;
    end
    if (k_tr) begin
      list_c[n_c[1:0]] = tr[CAW-1:0];
      n_c = n_c + 3'd1;
    end
    if (k_bl) begin
      list_c[n_c[1:0]] = bl[CAW-1:0];
      n_c = n_c + 3'd1;
    end
    if (k_br) begin
      list_c[n_c[1:0]] = br[CAW-1:0];
      n_c = n_c + 3'd1;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer: next state and memory port control
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ugb_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  logic res_load;

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    div_start  = 1'b0;
    res_load   = 1'b0;
    cm_we      = 1'b0;
    cm_waddr   = sw;
    cm_wdata   = '0;
    cm_raddr   = list[li[1:0]];
    im_we      = 1'b0;
    im_waddr   = place_addr[IAW-1:0];
    im_raddr   = q_addr[IAW-1:0];
    kb_we      = 1'b0;
    kb_waddr   = k[KAW-1:0];
    kb_wdata   = in_rng ? im_rdata : '0;
    kb_raddr   = ei[KAW-1:0];
    unique case (state)
      ugb_pkg::S_INIT: begin
        cm_we = 1'b1;
        if (sw_last) begin
          state_next = ugb_pkg::S_IDLE;
        end
      end
      ugb_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          unique case (ugb_pkg::action_t'(action))
            ugb_pkg::ACT_CLEAR:  state_next = ugb_pkg::S_CLR;
            ugb_pkg::ACT_PREFIX: state_next = ugb_pkg::S_PFX_RD;
            ugb_pkg::ACT_COUNT,
            ugb_pkg::ACT_PLACE: begin
              state_next = (element_id < first_id) ? ugb_pkg::S_RESULT
                                                   : ugb_pkg::S_DIV_GO;
            end
            ugb_pkg::ACT_QUERY:  state_next = ugb_pkg::S_DIV_GO;
            default:             state_next = ugb_pkg::S_RESULT;
          endcase
        end
      end
      ugb_pkg::S_CLR: begin
        cm_we = 1'b1;
        if (sw_last) begin
          state_next = ugb_pkg::S_RESULT;
        end
      end
      ugb_pkg::S_PFX_RD: begin
        cm_raddr   = sw;
        state_next = ugb_pkg::S_PFX_WR;
      end
      ugb_pkg::S_PFX_WR: begin
        cm_we    = 1'b1;
        cm_wdata = sw_in_use ? {c_cnt, acc, CW'(0)} : {c_cnt, c_head, CW'(0)};
        state_next = sw_last ? ugb_pkg::S_RESULT : ugb_pkg::S_PFX_RD;
      end
      ugb_pkg::S_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ugb_pkg::S_DIV_WAIT;
      end
      ugb_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          state_next = (div_sel == 2'd3) ? ugb_pkg::S_MUL1 : ugb_pkg::S_DIV_GO;
        end
      end
      ugb_pkg::S_MUL1: state_next = ugb_pkg::S_IDX1;
      ugb_pkg::S_IDX1: state_next = ugb_pkg::S_MUL2;
      ugb_pkg::S_MUL2: state_next = ugb_pkg::S_IDX2;
      ugb_pkg::S_IDX2: state_next = ugb_pkg::S_SEL;
      ugb_pkg::S_SEL:  state_next = ugb_pkg::S_DISPATCH;
      ugb_pkg::S_DISPATCH: begin
        priority if (act == ugb_pkg::ACT_QUERY) begin
          state_next = (n == 3'd0) ? ugb_pkg::S_Q_DONE : ugb_pkg::S_Q_CELL_RD;
        end else if ((act == ugb_pkg::ACT_COUNT) && over) begin
          state_next = ugb_pkg::S_RESULT;
        end else begin
          state_next = (n == 3'd0) ? ugb_pkg::S_RESULT : ugb_pkg::S_CELL_RD;
        end
      end
      ugb_pkg::S_CELL_RD: state_next = ugb_pkg::S_CELL_WR;
      ugb_pkg::S_CELL_WR: begin
        // Cells of one box are distinct, so a write never meets the read
        // of the next cell at the same entry.
        cm_waddr = list[li[1:0]];
        if (act == ugb_pkg::ACT_COUNT) begin
          cm_we    = 1'b1;
          cm_wdata = {c_cnt + CW'(1), c_head, c_fill};
        end else if (place_ok) begin
          cm_we    = 1'b1;
          cm_wdata = {c_cnt, c_head, c_fill + CW'(1)};
          im_we    = 1'b1;
        end
        state_next = li_last ? ugb_pkg::S_RESULT : ugb_pkg::S_CELL_RD;
      end
      ugb_pkg::S_Q_CELL_RD:  state_next = ugb_pkg::S_Q_CELL_DAT;
      ugb_pkg::S_Q_CELL_DAT: state_next = ugb_pkg::S_Q_ITEM;
      ugb_pkg::S_Q_ITEM: begin
        if (cell_end || k_full) begin
          state_next = li_last ? ugb_pkg::S_Q_DONE : ugb_pkg::S_Q_CELL_RD;
        end else begin
          state_next = ugb_pkg::S_Q_ITEM_WR;
        end
      end
      ugb_pkg::S_Q_ITEM_WR: begin
        kb_we      = 1'b1;
        state_next = ugb_pkg::S_Q_ITEM;
      end
      ugb_pkg::S_Q_DONE: begin
        state_next = (k == '0) ? ugb_pkg::S_RESULT : ugb_pkg::S_EMIT_RD;
      end
      ugb_pkg::S_EMIT_RD: state_next = ugb_pkg::S_EMIT_LD;
      ugb_pkg::S_EMIT_LD: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = ((ei + KW'(1)) == k) ? ugb_pkg::S_IDLE : ugb_pkg::S_EMIT_RD;
        end
      end
      ugb_pkg::S_RESULT: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = ugb_pkg::S_IDLE;
        end
      end
      default: state_next = ugb_pkg::S_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Datapath registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      sw    <= '0;
    end else begin
      unique case (state)
        ugb_pkg::S_INIT: sw <= sw + CAW'(1);
        ugb_pkg::S_IDLE: begin
          if (item_valid) begin
            act       <= ugb_pkg::action_t'(action);
            id_r      <= element_id;
            px_r      <= pos_x;
            py_r      <= pos_y;
            sx_r      <= size_x;
            sy_r      <= size_y;
            sw        <= '0;
            acc       <= '0;
            div_sel   <= 2'd0;
            li        <= 3'd0;
            k         <= '0;
            ei        <= '0;
            trunc     <= 1'b0;
            touched_r <= '0;
            status_r  <= ugb_pkg::ST_OK;
          end
        end
        ugb_pkg::S_CLR: begin
          sw    <= sw + CAW'(1);
          total <= '0;
        end
        ugb_pkg::S_PFX_WR: begin
          sw <= sw + CAW'(1);
          if (sw_in_use) begin
            acc <= acc + c_cnt;
          end
        end
        ugb_pkg::S_DIV_WAIT: begin
          if (div_done) begin
            qv[div_sel] <= div_q;
            div_sel     <= div_sel + 2'd1;
          end
        end
        ugb_pkg::S_MUL1: begin
          prod <= ugb_pkg::PROD_W'(qv[1][ugb_pkg::MAG_W-1:0])
                  * ugb_pkg::PROD_W'(num_columns);
        end
        ugb_pkg::S_IDX1: begin
          tl <= ugb_pkg::IDX_W'(qv[0]) + $signed(ugb_pkg::IDX_W'(prod));
          tr <= ugb_pkg::IDX_W'(qv[2]) + $signed(ugb_pkg::IDX_W'(prod));
        end
        ugb_pkg::S_MUL2: begin
          prod <= ugb_pkg::PROD_W'(qv[3][ugb_pkg::MAG_W-1:0])
                  * ugb_pkg::PROD_W'(num_columns);
        end
        ugb_pkg::S_IDX2: begin
          bl <= ugb_pkg::IDX_W'(qv[0]) + $signed(ugb_pkg::IDX_W'(prod));
          br <= ugb_pkg::IDX_W'(qv[2]) + $signed(ugb_pkg::IDX_W'(prod));
        end
        ugb_pkg::S_SEL: begin
          list      <= list_c;
          n         <= n_c;
          touched_r <= n_c;
        end
        ugb_pkg::S_DISPATCH: begin
          if (act == ugb_pkg::ACT_COUNT) begin
            if (over) begin
              status_r <= ugb_pkg::ST_FULL;
            end else begin
              total <= total + CW'(n);
            end
          end
        end
        ugb_pkg::S_CELL_WR: begin
          li <= li + 3'd1;
          if ((act == ugb_pkg::ACT_PLACE) && !place_ok) begin
            status_r <= ugb_pkg::ST_FULL;
          end
        end
        ugb_pkg::S_Q_CELL_DAT: begin
          q_count <= c_cnt;
          q_head  <= c_head;
          j       <= '0;
        end
        ugb_pkg::S_Q_ITEM: begin
          if (cell_end || k_full) begin
            li <= li + 3'd1;
            // Entries left in this cell with the buffer already full.
            if (!cell_end) begin
              trunc <= 1'b1;
            end
          end else begin
            in_rng <= (q_addr < (CW + 1)'(ITEM_CAPACITY));
          end
        end
        ugb_pkg::S_Q_ITEM_WR: begin
          k <= k + KW'(1);
          j <= j + CW'(1);
        end
        ugb_pkg::S_Q_DONE: begin
          status_r <= trunc ? ugb_pkg::ST_TRUNC : ugb_pkg::ST_OK;
        end
        ugb_pkg::S_EMIT_LD: begin
          if (out_free) begin
            ei <= ei + KW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Result register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      cells_touched <= touched_r;
      status        <= status_r;
      if (state == ugb_pkg::S_EMIT_LD) begin
        candidate_id <= kb_rdata;
        valid_res    <= 1'b1;
        last         <= ((ei + KW'(1)) == k);
      end else begin
        candidate_id <= '0;
        valid_res    <= 1'b0;
        last         <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // The counting round never books more entries than the item store holds.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(ITEM_CAPACITY))
    else $error("total item count exceeds store capacity");

  // The candidate buffer never overflows.
  a_cand_bound: assert property (@(posedge clk) disable iff (rst)
    k <= KW'(MAX_CANDIDATES))
    else $error("candidate count exceeds buffer depth");

  // No request is taken right after reset, at the start of the clearing pass.
  a_init_block: assert property (@(posedge clk)
    rst |=> !item_ready)
    else $error("request accepted during the reset clearing pass");

  // A candidate result is only loaded while collected candidates remain.
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (res_load && (state == ugb_pkg::S_EMIT_LD)) |-> (ei < k))
    else $error("candidate emitted beyond the collected count");

endmodule

`default_nettype wire
